/* hw/rtl/token_bucket_limiter_assert.svh */
// Assertion macros for the token bucket limiter.
// Included by token_bucket_limiter.sv; empty bodies when SYNTHESIS is defined.
`ifndef TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token bucket limiter: assertion failed");
// Next-cycle implication.
`define TBL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token bucket limiter: assertion failed");
`else
`define TBL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/tbl_pkg.sv */
// Types and constants for the token bucket limiter.
// No dependencies.
`timescale 1ns / 1ps

package tbl_pkg;

    typedef struct packed {
        logic        operation;
        logic [47:0] now_ms;
        logic [15:0] tokens_requested;
    } t_req;

    typedef struct packed {
        logic        granted;
        logic [31:0] available_q16;
        logic [25:0] wait_ms;
    } t_rsp;

    // operation codes carried in t_req.operation
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_BURST = 1'b1;

    localparam logic [31:0] RATE_RESET  = 32'd65536;
    localparam logic [15:0] BURST_RESET = 16'd10;
    // RATE_RESET split as quotient and remainder by 1000
    localparam logic [31:0] RQ_RESET    = 32'd65;
    localparam logic [9:0]  RR_RESET    = 10'd536;

    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [16:0] ONE_Q16_17  = 17'h1_0000;
    localparam logic [10:0] MS_PER_S    = 11'd1000;
    localparam logic [11:0] MS_X1       = 12'd1000;
    localparam logic [11:0] MS_X2       = 12'd2000;
    localparam logic [25:0] WAIT_NEVER  = 26'd65536000;

    localparam logic [5:0]  ELAPSED_LAST = 6'd47;  // 48 elapsed bits, MSB first
    localparam logic [5:0]  WAIT_LAST    = 6'd25;  // 26 quotient bits
    localparam logic [4:0]  RDIV_LAST    = 5'd31;  // 32 rate bits

endpackage

/* hw/rtl/token_bucket_limiter.sv */
// Token bucket rate limiter, top level: bit-serial refill and wait-time units.
// Depends on tbl_pkg and token_bucket_limiter_assert.svh.
`timescale 1ns / 1ps
`include "token_bucket_limiter_assert.svh"

//  channel  | handshake                         | payload
//  ---------+-----------------------------------+---------------------------
//  request  | i_in_valid / o_in_stall           | i_in_data  (t_req)
//  result   | o_out_valid / i_out_stall         | o_out_data (t_rsp)
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  One request at a time. With no refill due (first request, drain, time not
//  advancing) a request runs S_IDLE, S_APPLY, S_OUT; a refill adds S_REFILL
//  (48 elapsed-ms bits, one per cycle) and S_CAP before S_APPLY, and a wait
//  to compute adds S_WAIT (the wait divide, one quotient bit per cycle) after it.
//  A write to refill_rate starts a bit-serial split of the rate by 1000;
//  requests are stalled meanwhile. Reset is synchronous; the bucket comes up full.
//  A stalled result sits in the output register and the next request is still
//  accepted; its result then waits in S_OUT until the register drains.

module token_bucket_limiter import tbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_data,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REFILL,
        S_CAP,
        S_APPLY,
        S_WAIT,
        S_OUT
    } t_state;

    t_state      r_state;

    // configuration, plus rate = 1000*r_rq + r_rr
    logic [31:0] r_rate;
    logic [15:0] r_burst;
    logic [31:0] r_rq;          // doubles as the shift register of the rate split
    logic [9:0]  r_rr;
    logic        r_rdiv_busy;
    logic [4:0]  r_rdiv_cnt;

    // bucket state
    logic [31:0] r_bucket;
    logic [47:0] r_last;
    logic        r_known;

    // transaction in flight
    logic        r_drain;
    logic [47:0] r_now;
    logic [15:0] r_req;
    logic [31:0] r_level;
    logic [47:0] r_elapsed;     // shifted out MSB first
    logic [31:0] r_q;           // running floor(elapsed*rate/1000)
    logic [9:0]  r_qrem;        // and its remainder
    logic        r_sat;
    logic [5:0]  r_cnt;
    logic        r_grant;
    logic [31:0] r_avail;
    logic [25:0] r_num;         // dividend in, quotient out
    logic [31:0] r_wrem;

    logic        r_out_valid;
    t_rsp        r_out;

    // combinational helpers
    logic        cfg_wr;
    logic        in_acc;
    logic        out_load;
    logic [48:0] el_diff;
    logic        el_adv;
    logic [11:0] rd_t;
    logic        rd_ge;
    logic [9:0]  n_rdiv_rem;
    logic        rf_bit;
    logic [11:0] rf_t;
    logic [1:0]  rf_carry;
    logic [9:0]  n_qrem;
    logic [33:0] n_qsum;
    logic [31:0] cap;
    logic [32:0] lvl_sum;
    logic [31:0] n_level;
    logic [31:0] need;
    logic        ap_ok;
    logic [31:0] ap_avail;
    logic [16:0] short_q16;
    logic [26:0] n_num;
    logic [32:0] wd_t;
    logic        wd_ge;
    logic [32:0] wd_sub;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign o_in_stall = !((r_state == S_IDLE) && !r_rdiv_busy);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        unique case (paddr[2])
            REG_RATE:  prdata = r_rate;
            REG_BURST: prdata = {16'h0000, r_burst};
            default:   prdata = 32'h0;
        endcase
    end

    always_comb begin
        // rate split: restoring divide by 1000, one bit per cycle while no
        // register write comes in; remainder kept in r_rr while busy
        rd_t       = {1'b0, r_rr, r_rq[31]};
        rd_ge      = rd_t >= {1'b0, MS_PER_S};
        n_rdiv_rem = rd_ge ? 10'(rd_t - {1'b0, MS_PER_S}) : rd_t[9:0];

        // elapsed time: one subtract gives both difference and direction
        el_diff = {1'b0, i_in_data.now_ms} - {1'b0, r_last};
        el_adv  = !el_diff[48] && (el_diff[47:0] != 48'h0);

        // refill step: X = 2X + e*rate, held as 1000*q + rem
        rf_bit   = r_elapsed[47];
        rf_t     = {1'b0, r_qrem, 1'b0} + (rf_bit ? {2'b00, r_rr} : 12'h0);
        rf_carry = (rf_t >= MS_X2) ? 2'd2 : ((rf_t >= MS_X1) ? 2'd1 : 2'd0);
        unique case (rf_carry)
            2'd2:    n_qrem = 10'(rf_t - MS_X2);
            2'd1:    n_qrem = 10'(rf_t - MS_X1);
            default: n_qrem = rf_t[9:0];
        endcase
        n_qsum = {1'b0, r_q, 1'b0} + (rf_bit ? {2'b00, r_rq} : 34'h0)
               + {32'h0, rf_carry};

        // cap at the burst size; a level above a lowered cap is clipped too
        cap     = {r_burst, 16'h0000};
        lvl_sum = {1'b0, r_level} + {1'b0, r_q};
        n_level = (r_sat || (lvl_sum >= {1'b0, cap})) ? cap : lvl_sum[31:0];

        // grant decision
        need  = {r_req, 16'h0000};
        ap_ok = r_level >= need;
        if (r_drain) begin
            ap_avail = 32'h0;
        end else if (ap_ok) begin
            ap_avail = r_level - need;
        end else begin
            ap_avail = r_level;
        end

        // (1.0 - avail) * 1000 as shifts; only used when avail < 1.0
        short_q16 = ONE_Q16_17 - {1'b0, ap_avail[15:0]};
        n_num     = {short_q16, 10'h000} - {6'h00, short_q16, 4'h0}
                  - {7'h00, short_q16, 3'h0};

        // wait divide: restoring, one quotient bit per cycle
        wd_t   = {r_wrem, r_num[25]};
        wd_ge  = wd_t >= {1'b0, r_rate};
        wd_sub = wd_t - {1'b0, r_rate};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_burst     <= BURST_RESET;
            r_rq        <= RQ_RESET;
            r_rr        <= RR_RESET;
            r_rdiv_busy <= 1'b0;
            r_rdiv_cnt  <= '0;
            r_bucket    <= {BURST_RESET, 16'h0000};
            r_last      <= '0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes; a rate write restarts the split
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_RATE: begin
                        r_rate      <= pwdata;
                        r_rq        <= pwdata;
                        r_rr        <= '0;
                        r_rdiv_cnt  <= RDIV_LAST;
                        r_rdiv_busy <= 1'b1;
                    end
                    REG_BURST: begin
                        r_burst <= pwdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end else if (r_rdiv_busy) begin
                r_rq       <= {r_rq[30:0], rd_ge};
                r_rr       <= n_rdiv_rem;
                r_rdiv_cnt <= r_rdiv_cnt - 5'd1;
                if (r_rdiv_cnt == '0) begin
                    r_rdiv_busy <= 1'b0;
                end
            end

            // emptied on acceptance unless a new result is loaded in its place
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_drain <= (i_in_data.operation == OP_DRAIN);
                        r_now   <= i_in_data.now_ms;
                        r_req   <= i_in_data.tokens_requested;
                        if (!r_known) begin
                            // first request only records the time
                            r_known <= 1'b1;
                            r_last  <= i_in_data.now_ms;
                            r_level <= r_bucket;
                            r_state <= S_APPLY;
                        end else if (el_adv && (i_in_data.operation == OP_ACQUIRE)) begin
                            r_elapsed <= el_diff[47:0];
                            r_q       <= '0;
                            r_qrem    <= '0;
                            r_sat     <= 1'b0;
                            r_cnt     <= ELAPSED_LAST;
                            r_state   <= S_REFILL;
                        end else begin
                            r_level <= r_bucket;
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_REFILL: begin
                    r_elapsed <= {r_elapsed[46:0], 1'b0};
                    r_q       <= n_qsum[31:0];
                    r_qrem    <= n_qrem;
                    r_sat     <= r_sat || (n_qsum[33:32] != 2'b00);
                    r_cnt     <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_level <= r_bucket;
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_level <= n_level;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_avail <= ap_avail;
                    r_grant <= !r_drain && ap_ok;
                    if (r_drain || ap_ok) begin
                        r_bucket <= ap_avail;
                        r_last   <= r_now;
                    end
                    if (ap_avail >= ONE_Q16) begin
                        r_num   <= '0;
                        r_state <= S_OUT;
                    end else if (r_rate == '0) begin
                        r_num   <= WAIT_NEVER;
                        r_state <= S_OUT;
                    end else begin
                        r_num   <= n_num[25:0];
                        r_wrem  <= '0;
                        r_cnt   <= WAIT_LAST;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_num  <= {r_num[24:0], wd_ge};
                    r_wrem <= wd_ge ? wd_sub[31:0] : wd_t[31:0];
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid         <= 1'b1;
                        r_out.granted       <= r_grant;
                        r_out.available_q16 <= r_avail;
                        r_out.wait_ms       <= r_num;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the user must keep the rate split between transactions; not enforced
    `TBL_ASSERT_IMP(a_rdiv_idle, i_clk, i_rst_n, r_rdiv_busy, r_state == S_IDLE)
    // a whole token on hand means no wait
    `TBL_ASSERT_IMP(a_wait_zero, i_clk, i_rst_n,
        o_out_valid && (o_out_data.available_q16 >= ONE_Q16),
        o_out_data.wait_ms == '0)
    // a granted result reports the level that was stored
    `TBL_ASSERT_NXT(a_grant_level, i_clk, i_rst_n, out_load && r_grant,
        r_bucket == o_out_data.available_q16)

endmodule

/* verif/token_bucket_limiter_tb.sv */
// Self-checking testbench for token_bucket_limiter: directed table, then randomised
// request transactions over several register settings, checked by a bucket predictor.
// Depends on tbl_pkg and the token_bucket_limiter RTL.
`timescale 1ns / 1ps

module token_bucket_limiter_tb;
    import tbl_pkg::*;

    localparam int GAP_MAX        = 18;    // longest idle per transaction, either side
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_AT        = 500;   // result count at which the long hold-off starts
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either channel
    localparam int PHASE_ITEMS    = 310;
    localparam int N_PHASES       = 6;
    localparam int N_ROWS         = 18;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rsp        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    token_bucket_limiter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Directed table. Rows with known set carry a hand-worked result;
    // the rest are checked against the predictor. All at reset settings
    // (1 token/s, burst of 10).
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        op;
        logic [47:0] now;
        logic [15:0] tok;
        logic        known;
        logic        g;
        logic [31:0] av;
        logic [25:0] wt;
    } t_dir_row;

    t_dir_row dir_rows [0:N_ROWS-1] = '{
        // first transaction: denied, but the time is still recorded
        '{OP_ACQUIRE, 48'd1000, 16'd11, 1'b1, 1'b0, 32'd655360, 26'd0},
        '{OP_ACQUIRE, 48'd1000, 16'd3,  1'b1, 1'b1, 32'd458752, 26'd0},
        // time not advancing: no refill
        '{OP_ACQUIRE, 48'd1000, 16'd8,  1'b1, 1'b0, 32'd458752, 26'd0},
        // zero tokens always granted
        '{OP_ACQUIRE, 48'd1000, 16'd0,  1'b1, 1'b1, 32'd458752, 26'd0},
        '{OP_DRAIN,   48'd1500, 16'd0,  1'b1, 1'b0, 32'd0,      26'd1000},
        // half a token after 500 ms, not enough
        '{OP_ACQUIRE, 48'd2000, 16'd1,  1'b1, 1'b0, 32'd32768,  26'd500},
        // denial above kept the old time, so a full second has passed
        '{OP_ACQUIRE, 48'd2500, 16'd1,  1'b1, 1'b1, 32'd0,      26'd1000},
        // time going backwards: granted zero-token acquire stores the earlier time
        '{OP_ACQUIRE, 48'd1000, 16'd0,  1'b1, 1'b1, 32'd0,      26'd1000},
        // huge elapsed time saturates the refill; full bucket, max request denied
        '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 32'd655360, 26'd0},
        '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFF, 16'd10,   1'b1, 1'b1, 32'd0,      26'd1000},
        '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFF, 16'd0,    1'b1, 1'b1, 32'd0,      26'd1000},
        // drain ignores the token field and stores time zero
        '{OP_DRAIN,   48'd0,              16'hFFFF, 1'b1, 1'b0, 32'd0,      26'd1000},
        '{OP_ACQUIRE, 48'hAAAA_AAAA_AAAA, 16'h5555, 1'b1, 1'b0, 32'd655360, 26'd0},
        '{OP_ACQUIRE, 48'h5555_5555_5555, 16'd2,    1'b1, 1'b1, 32'd524288, 26'd0},
        // single-millisecond refills and fractional waits: predictor only
        '{OP_ACQUIRE, 48'h5555_5555_5556, 16'd8,    1'b0, 1'b0, 32'd0, 26'd0},
        '{OP_ACQUIRE, 48'h5555_5555_593D, 16'd0,    1'b0, 1'b0, 32'd0, 26'd0},
        '{OP_DRAIN,   48'h5555_5555_593D, 16'd0,    1'b0, 1'b0, 32'd0, 26'd0},
        '{OP_ACQUIRE, 48'h5555_5555_6000, 16'd1,    1'b0, 1'b0, 32'd0, 26'd0}
    };

    // ------------------------------------------------------------------
    // Bucket predictor: own copy of the registers and state.
    // ------------------------------------------------------------------
    bit [31:0] mdl_rate;
    bit [15:0] mdl_burst;
    bit [63:0] mdl_level;
    bit [47:0] mdl_last;
    bit        mdl_seen;

    // level after el_ms (> 0) of refill, capped at the burst size
    function automatic bit [63:0] refill_after(bit [47:0] el_ms);
        bit [63:0] cap;
        bit [63:0] whole_s;
        bit [63:0] rest_ms;
        bit [63:0] added;
        bit [63:0] sum;
        cap     = {32'b0, mdl_burst, 16'b0};
        whole_s = 64'(el_ms) / 64'd1000;
        rest_ms = 64'(el_ms) % 64'd1000;
        if (mdl_rate == 32'd0) begin
            added = 64'd0;
        end else if (whole_s >= 64'h1_0000_0000) begin
            added = 64'h2_0000_0000;
        end else begin
            added = whole_s * 64'(mdl_rate);
            if (added >= 64'h2_0000_0000) begin
                added = 64'h2_0000_0000;
            end else begin
                added = added + (rest_ms * 64'(mdl_rate)) / 64'd1000;
            end
        end
        sum = mdl_level + added;
        return (sum < cap) ? sum : cap;
    endfunction

    // result of one request transaction; updates the predictor state
    function automatic t_rsp bucket_predict(t_req rq);
        bit [63:0] lvl;
        bit [63:0] need;
        bit [63:0] avail;
        bit [63:0] wt;
        bit        g;
        t_rsp      r;
        lvl  = mdl_level;
        need = {32'b0, rq.tokens_requested, 16'b0};
        g    = 1'b0;
        if (!mdl_seen) begin
            mdl_seen = 1'b1;
            mdl_last = rq.now_ms;
        end else if (rq.now_ms > mdl_last) begin
            lvl = refill_after(rq.now_ms - mdl_last);
        end
        if (rq.operation == OP_DRAIN) begin
            mdl_level = 64'd0;
            mdl_last  = rq.now_ms;
            avail     = 64'd0;
        end else if (lvl >= need) begin
            mdl_level = lvl - need;
            mdl_last  = rq.now_ms;
            g         = 1'b1;
            avail     = mdl_level;
        end else begin
            avail = lvl;  // refilled level is reported but not kept
        end
        if (avail >= 64'(ONE_Q16)) begin
            wt = 64'd0;
        end else if (mdl_rate == 32'd0) begin
            wt = 64'(WAIT_NEVER);
        end else begin
            wt = ((64'(ONE_Q16) - avail) * 64'd1000) / 64'(mdl_rate);
        end
        r.granted       = g;
        r.available_q16 = avail[31:0];
        r.wait_ms       = wt[25:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_rsp      pending_rsp [$];
    int        errors      = 0;
    int        n_requests  = 0;
    int        n_drains    = 0;
    int        n_granted   = 0;
    int        n_denied    = 0;
    int        n_results   = 0;
    int        n_readbacks = 0;
    int        n_settings  = 0;
    int        idle_cycles = 0;
    bit        tx_quiet    = 1'b0;
    bit        rx_quiet    = 1'b0;
    bit [47:0] t_cursor;
    int unsigned step_max;

    // ------------------------------------------------------------------
    // Register port: setup cycle then access cycle; called at a falling edge.
    // ------------------------------------------------------------------
    task automatic cfg_read_check(logic idx, bit [31:0] want);
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        n_readbacks++;
        if (got !== want) begin
            $error("prdata[%0d]: expected %0h, got %0h", idx, want, got);
            errors++;
        end
    endtask

    task automatic cfg_write(logic idx, bit [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_RATE) begin
            mdl_rate = val;
        end else begin
            mdl_burst = val[15:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cfg_read_check(idx, (idx == REG_RATE) ? val : {16'b0, val[15:0]});
    endtask

    // ------------------------------------------------------------------
    // Request side. Valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic send_request(t_req rq, bit known, t_rsp known_rsp);
        t_rsp p;
        int   gap;
        if (n_requests % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = rq;
        do @(posedge i_clk); while (o_in_stall);
        p = bucket_predict(rq);
        pending_rsp.push_back(known ? known_rsp : p);
        n_requests++;
        if (rq.operation == OP_DRAIN) n_drains++;
        @(negedge i_clk);
    endtask

    // block idle: every result in, then SETTLE_CYCLES on top
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random request: mostly time moving forward at a pace that makes the
    // refill matter for the current rate, plus stalls of time, steps back,
    // wild timestamps and the odd drain.
    function automatic t_req random_request();
        t_req rq;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            t_cursor = t_cursor + 48'($urandom_range(0, step_max));
        end else if (r < 78) begin
            t_cursor = t_cursor + 48'($urandom_range(0, 40)) * 48'(step_max);
        end else if (r < 86) begin
            t_cursor = t_cursor;  // same time again
        end else if (r < 94) begin
            t_cursor = t_cursor - 48'($urandom_range(0, step_max));
        end else if (r < 98) begin
            t_cursor = {16'($urandom()), $urandom()};
        end else begin
            t_cursor = ($urandom_range(0, 1) == 1) ? 48'hFFFF_FFFF_FFFF : 48'd0;
        end
        rq.now_ms    = t_cursor;
        rq.operation = ($urandom_range(0, 99) < 8) ? OP_DRAIN : OP_ACQUIRE;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            rq.tokens_requested = 16'($urandom_range(0, 3));
        end else if (r < 85) begin
            rq.tokens_requested = 16'($urandom_range(0, mdl_burst));
        end else if (r < 92) begin
            rq.tokens_requested = 16'd0;
        end else begin
            rq.tokens_requested = 16'($urandom());
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random hold-offs, one long one to back the block up.
    // ------------------------------------------------------------------
    initial begin
        int   k;
        t_rsp want;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (n_results == HOLD_AT) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (n_results % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            k = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (k > 0) begin
                i_out_stall = 1'b1;
                repeat (k) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            n_results++;
            if (o_out_data.granted === 1'b1) begin
                n_granted++;
            end
            if (pending_rsp.size() == 0) begin
                $error("result transaction with nothing outstanding: %p", o_out_data);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted,
                           o_out_data.granted);
                    errors++;
                end
                if (o_out_data.available_q16 !== want.available_q16) begin
                    $error("available_q16: expected %0h, got %0h", want.available_q16,
                           o_out_data.available_q16);
                    errors++;
                end
                if (o_out_data.wait_ms !== want.wait_ms) begin
                    $error("wait_ms: expected %0d, got %0d", want.wait_ms,
                           o_out_data.wait_ms);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("token_bucket_limiter test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_req        rq;
        t_rsp        tr;
        bit [31:0]   ph_rate  [0:N_PHASES-1];
        bit [15:0]   ph_burst [0:N_PHASES-1];
        bit [63:0]   span;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        mdl_rate  = RATE_RESET;
        mdl_burst = BURST_RESET;
        mdl_level = {32'b0, BURST_RESET, 16'b0};  // bucket starts full
        mdl_last  = '0;
        mdl_seen  = 1'b0;

        // settings per phase; phase 0 keeps the reset values
        ph_rate[0] = RATE_RESET;                  ph_burst[0] = BURST_RESET;
        ph_rate[1] = 32'hFFFF_FFFF;               ph_burst[1] = 16'hFFFF;
        // burst dropped under a nearly full bucket: clipped at the next refill
        ph_rate[2] = 32'd1;                       ph_burst[2] = 16'd1;
        ph_rate[3] = $urandom_range(1, 32'h00FF_FFFF);
        ph_burst[3] = 16'($urandom_range(1, 64));
        ph_rate[4] = 32'd327803;                  ph_burst[4] = 16'd3;
        ph_rate[5] = $urandom() | 32'd1;          ph_burst[5] = 16'hFFFF;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        cfg_read_check(REG_RATE, RATE_RESET);
        cfg_read_check(REG_BURST, {16'b0, BURST_RESET});

        for (int i = 0; i < N_ROWS; i++) begin
            rq.operation        = dir_rows[i].op;
            rq.now_ms           = dir_rows[i].now;
            rq.tokens_requested = dir_rows[i].tok;
            tr.granted          = dir_rows[i].g;
            tr.available_q16    = dir_rows[i].av;
            tr.wait_ms          = dir_rows[i].wt;
            send_request(rq, dir_rows[i].known, tr);
        end
        t_cursor = 48'h5555_5555_6000;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                cfg_write(REG_RATE, ph_rate[ph]);
                cfg_write(REG_BURST, {16'b0, ph_burst[ph]});
            end
            n_settings++;
            // time step that buys about two tokens at this rate
            span     = 64'd131072000 / 64'(mdl_rate) + 64'd2;
            step_max = (span > 64'd200_000_000) ? 200_000_000 : span[31:0];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                tr = '0;
                send_request(random_request(), 1'b0, tr);
            end
        end

        settle();

        n_denied = n_requests - n_drains - n_granted;
        $display("Ran %0d requests over %0d register settings: %0d granted, %0d denied, %0d drains",
                 n_requests, n_settings, n_granted, n_denied, n_drains);
        $display("%0d results checked, %0d register read-backs, one %0d-cycle output hold-off",
                 n_results, n_readbacks, HOLD_CYCLES);
        if (errors == 0) begin
            $display("token_bucket_limiter test passed");
        end else begin
            $display("token_bucket_limiter test failed");
        end
        $finish;
    end

endmodule
